>>> rtl/spes_pkg.sv
// ----------------------------------------------------------------------------
// spes_pkg: shared types and constants of the stimulation pulse event sequencer
// Command and transaction layouts, operation codes and small helpers.
// ----------------------------------------------------------------------------
package spes_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned CHANNELS    = 9;

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [8:0]  CHAN_MASK   = 9'((1 << CHANNELS) - 1);
  localparam logic [11:0] DAC_MAX     = 12'd4095;
  localparam logic [7:0]  REPEAT_MODE = 8'd1;

  // Item kinds; code three behaves as a next-event item.
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;

  // Result status codes.
  localparam logic [1:0] STAT_PUSHED  = 2'd0;
  localparam logic [1:0] STAT_DROPPED = 2'd1;
  localparam logic [1:0] STAT_EVENT   = 2'd2;
  localparam logic [1:0] STAT_STOP    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PULSE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_DAC_LEAD     = 2'd1;
  localparam logic [1:0] CFG_START_MARGIN = 2'd2;

  localparam logic [15:0] PULSE_WIDTH_RST  = 16'd10;
  localparam logic [15:0] DAC_LEAD_RST     = 16'd5;
  localparam logic [15:0] START_MARGIN_RST = 16'd1000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  mode;
    logic [8:0]  pin_mask;
    logic [15:0] amplitude;
    logic [31:0] period;
    logic [31:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_fall;
    logic [31:0] dac_event_tick;
    logic [31:0] out_event_tick;
    logic [11:0] dac_value;
    logic [8:0]  set_pins;
    logic [8:0]  clear_pins;
    logic [7:0]  event_mode;
    logic        mode_update;
    logic [31:0] stop_tick;
    logic [6:0]  queue_level;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  mode;
    logic [8:0]  mask;
    logic [15:0] amp;
    logic [31:0] period;
  } cmd_t;

  // Request to the shared adder: a + b, or a - b when sub is set.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

>>> rtl/spes_in_if.sv
// ----------------------------------------------------------------------------
// spes_in_if: input channel of the pulse event sequencer
// Valid/ready channel that carries one input item per transaction.
// ----------------------------------------------------------------------------
interface spes_in_if;
  import spes_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/spes_out_if.sv
// ----------------------------------------------------------------------------
// spes_out_if: result channel of the pulse event sequencer
// Valid/ready channel that carries one result item per transaction.
// ----------------------------------------------------------------------------
interface spes_out_if;
  import spes_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/stim_pulse_event_sequencer.sv
// ----------------------------------------------------------------------------
// stim_pulse_event_sequencer: turns queued stimulation commands into pulse events
// Flow: a push or a falling event goes straight to S_EMIT; a rising event
// passes S_THRESH, S_FETCH, S_CMP, S_LEAD, S_FALLAT and S_ADV (S_START first for
// a start item), with S_FETCH and S_CMP again for every short command discarded;
// an empty queue answers from S_FETCH. One transaction at a time; the input is
// ready again once the result is in the output register.
// Reset (rst_ni low, asynchronous) empties the queue and loads the register defaults.
// ----------------------------------------------------------------------------
module stim_pulse_event_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  spes_in_if.sink     item_i,
  spes_out_if.source  result_o
);
  import spes_pkg::*;

  // The sequencer steps one item through a chain of states. Every tick sum,
  // difference and the short-command compare goes through one shared adder.
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_THRESH,
    S_FETCH,
    S_CMP,
    S_LEAD,
    S_FALLAT,
    S_ADV,
    S_EMIT
  } state_e;

  state_e           state_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W-1:0] wr_ptr_q;
  logic [LEVEL_W-1:0] fill_q;
  logic             fall_next_q;
  logic [31:0]      next_rise_q;
  logic [31:0]      fall_at_q;
  logic [31:0]      last_trigger_q;
  logic [15:0]      pulse_width_q;
  logic [15:0]      dac_lead_q;
  logic [15:0]      start_margin_q;
  logic             out_valid_q;

  // Datapath registers without reset.
  logic [31:0]      now_q;
  logic [16:0]      thr_q;
  logic [31:0]      dac_tick_q;
  out_item_t        res_q;
  out_item_t        out_data_q;

  out_item_t  res_d;
  out_item_t  out_d;
  logic       item_acc;
  logic       full;
  logic       push_ok;
  logic       out_load;
  logic       is_short;
  logic       keep;
  alu_req_t   alu_req;
  logic [32:0] alu_sum;
  cmd_t       wr_cmd;
  cmd_t       rd_cmd;
  logic       rd_en;

  assign item_i.ready    = (state_q == S_IDLE);
  assign item_acc        = item_i.valid && item_i.ready;
  assign full            = (fill_q == LEVEL_W'(QUEUE_DEPTH));
  assign push_ok         = item_acc && (item_i.payload.kind == KIND_PUSH) && !full;
  assign out_load        = (state_q == S_EMIT) && (!out_valid_q || result_o.ready);
  assign result_o.valid  = out_valid_q;
  assign result_o.payload = out_data_q;

  // Commands are written straight from the accepted transaction.
  assign wr_cmd.mode   = item_i.payload.mode;
  assign wr_cmd.mask   = item_i.payload.pin_mask;
  assign wr_cmd.amp    = item_i.payload.amplitude;
  assign wr_cmd.period = item_i.payload.period;

  // The head command is read in S_FETCH and held until the next fetch.
  assign rd_en = (state_q == S_FETCH) && (fill_q != '0);

  spes_cmd_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (push_ok),
    .wr_addr_i (wr_ptr_q),
    .wr_data_i (wr_cmd),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_ptr_q),
    .rd_data_o (rd_cmd)
  );

  // Operand selection for the shared adder, one operation per state.
  always_comb begin
    alu_req = '0;
    case (state_q)
      S_START: begin
        alu_req.a = now_q;
        alu_req.b = 32'(start_margin_q);
      end
      S_THRESH: begin
        alu_req.a = 32'(pulse_width_q);
        alu_req.b = 32'(dac_lead_q);
      end
      S_FETCH: begin
        alu_req.a = last_trigger_q;
        alu_req.b = 32'd1;
      end
      S_CMP: begin
        // Borrow-free thr - period means period <= pulse width + lead.
        alu_req.a   = 32'(thr_q);
        alu_req.b   = rd_cmd.period;
        alu_req.sub = 1'b1;
      end
      S_LEAD: begin
        alu_req.a   = next_rise_q;
        alu_req.b   = 32'(dac_lead_q);
        alu_req.sub = 1'b1;
      end
      S_FALLAT: begin
        alu_req.a = next_rise_q;
        alu_req.b = 32'(pulse_width_q);
      end
      S_ADV: begin
        alu_req.a = next_rise_q;
        alu_req.b = rd_cmd.period;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  spes_addsub u_addsub (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  assign is_short = alu_sum[32];
  // A lone repeating command stays at the head unless it is too short.
  assign keep = (fill_q == LEVEL_W'(1)) && (rd_cmd.mode == REPEAT_MODE) && !is_short;

  // Sequencer, queue pointers, timing state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      rd_ptr_q       <= '0;
      wr_ptr_q       <= '0;
      fill_q         <= '0;
      fall_next_q    <= 1'b0;
      next_rise_q    <= '0;
      fall_at_q      <= '0;
      last_trigger_q <= '0;
      pulse_width_q  <= PULSE_WIDTH_RST;
      dac_lead_q     <= DAC_LEAD_RST;
      start_margin_q <= START_MARGIN_RST;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PULSE_WIDTH:  pulse_width_q  <= cfg_data_i;
          CFG_DAC_LEAD:     dac_lead_q     <= cfg_data_i;
          CFG_START_MARGIN: start_margin_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (item_acc) begin
            case (item_i.payload.kind)
              KIND_PUSH: begin
                if (!full) begin
                  wr_ptr_q <= ptr_inc(wr_ptr_q);
                  fill_q   <= fill_q + LEVEL_W'(1);
                end
                state_q <= S_EMIT;
              end
              KIND_START: begin
                state_q <= S_START;
              end
              default: begin
                if (fall_next_q) begin
                  last_trigger_q <= fall_at_q;
                  fall_next_q    <= 1'b0;
                  state_q        <= S_EMIT;
                end else begin
                  state_q <= S_THRESH;
                end
              end
            endcase
          end
        end
        S_START: begin
          // A start drops any pending fall and begins with a rise.
          next_rise_q <= alu_sum[31:0];
          fall_next_q <= 1'b0;
          state_q     <= S_THRESH;
        end
        S_THRESH: begin
          state_q <= S_FETCH;
        end
        S_FETCH: begin
          state_q <= (fill_q == '0) ? S_EMIT : S_CMP;
        end
        S_CMP: begin
          if (!keep) begin
            rd_ptr_q <= ptr_inc(rd_ptr_q);
            fill_q   <= fill_q - LEVEL_W'(1);
          end
          state_q <= is_short ? S_FETCH : S_LEAD;
        end
        S_LEAD: begin
          last_trigger_q <= next_rise_q;
          state_q        <= S_FALLAT;
        end
        S_FALLAT: begin
          fall_at_q <= alu_sum[31:0];
          state_q   <= S_ADV;
        end
        S_ADV: begin
          next_rise_q <= alu_sum[31:0];
          fall_next_q <= 1'b1;
          state_q     <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result assembly: the result under construction is updated in the states
  // that decide it and otherwise holds.
  always_comb begin
    res_d = res_q;
    case (state_q)
      S_IDLE: begin
        if (item_acc) begin
          res_d = '0;
          if (item_i.payload.kind == KIND_PUSH) begin
            res_d.status = full ? STAT_DROPPED : STAT_PUSHED;
          end else if (item_i.payload.kind != KIND_START && fall_next_q) begin
            res_d.status         = STAT_EVENT;
            res_d.is_fall        = 1'b1;
            res_d.dac_event_tick = fall_at_q;
            res_d.out_event_tick = fall_at_q;
          end
        end
      end
      S_FETCH: begin
        if (fill_q == '0) begin
          res_d           = '0;
          res_d.status    = STAT_STOP;
          res_d.stop_tick = alu_sum[31:0];
        end
      end
      S_ADV: begin
        res_d                = '0;
        res_d.status         = STAT_EVENT;
        res_d.dac_event_tick = dac_tick_q;
        res_d.out_event_tick = last_trigger_q;
        res_d.dac_value      = (|rd_cmd.amp[15:12]) ? DAC_MAX : rd_cmd.amp[11:0];
        res_d.set_pins       = rd_cmd.mask & CHAN_MASK;
        res_d.clear_pins     = ~rd_cmd.mask & CHAN_MASK;
        res_d.event_mode     = rd_cmd.mode;
        res_d.mode_update    = 1'b1;
      end
      default: ;
    endcase
  end

  // The queue level is taken when the result moves to the output register.
  always_comb begin
    out_d             = res_q;
    out_d.queue_level = 7'(fill_q);
  end

  // Datapath registers and the output register.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    case (state_q)
      S_IDLE: begin
        if (item_acc) begin
          now_q <= item_i.payload.now_tick;
        end
      end
      S_THRESH: begin
        thr_q <= alu_sum[16:0];
      end
      S_LEAD: begin
        dac_tick_q <= alu_sum[31:0];
      end
      default: ;
    endcase

    if (out_load) begin
      out_data_q <= out_d;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LEVEL_W'(QUEUE_DEPTH))
    else $error("queue fill count exceeds its depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("empty queue with differing pointers");

  a_rise_arms_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_q.status == STAT_EVENT && !res_q.is_fall) |-> fall_next_q)
    else $error("rising event issued without a pending fall");

  a_item_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc |=> (state_q != S_IDLE))
    else $error("accepted transaction produced no work");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && !result_o.ready) |=> (state_q == S_EMIT))
    else $error("result left the sequencer while the output was stalled");
endmodule

>>> rtl/spes_addsub.sv
// ----------------------------------------------------------------------------
// spes_addsub: shared 32-bit adder/subtractor
// Returns the 33-bit sum; on subtraction bit 32 is set when a >= b.
// ----------------------------------------------------------------------------
module spes_addsub (
  input  spes_pkg::alu_req_t req_i,
  output logic [32:0]        sum_o
);
  import spes_pkg::*;

  logic [31:0] b_op;

  assign b_op  = req_i.b ^ {32{req_i.sub}};
  assign sum_o = {1'b0, req_i.a} + {1'b0, b_op} + {32'd0, req_i.sub};
endmodule

>>> rtl/spes_cmd_store.sv
// ----------------------------------------------------------------------------
// spes_cmd_store: command memory of the pulse event sequencer
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spes_cmd_store (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [spes_pkg::PTR_W-1:0] wr_addr_i,
  input  spes_pkg::cmd_t             wr_data_i,
  input  logic                       rd_en_i,
  input  logic [spes_pkg::PTR_W-1:0] rd_addr_i,
  output spes_pkg::cmd_t             rd_data_o
);
  import spes_pkg::*;

  cmd_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end
endmodule
